### rtl/pgb_pkg.sv
// Shared types, constants and helpers for the planar glyph blitter.
// Used by every module of the blitter; depends on nothing else.
package pgb_pkg;

	localparam int VIEW_WIDTH     = 192;
	localparam int VIEW_HEIGHT    = 256;
	localparam int ROW_BYTES      = 24;
	localparam int PLANES         = 4;
	localparam int GLYPHS_PER_ROW = 16;
	localparam int GLYPH_SIZE     = 8;

	localparam int LINE_BYTES  = PLANES * ROW_BYTES;
	localparam int STORE_DEPTH = 2048;
	localparam int GIDX_W      = $clog2(STORE_DEPTH);
	localparam int ADDR_W      = 15;
	localparam int BYTE_W      = 8;
	localparam int CODE_W      = 8;
	localparam int POS_W       = 10;
	localparam int POS_CMP_W   = POS_W + 2;
	localparam int COLOUR_W    = 4;
	localparam int SHIFT_W     = 3;
	localparam int ROW_W       = $clog2(GLYPH_SIZE);
	localparam int PLANE_W     = (PLANES > 1) ? $clog2(PLANES) : 1;
	localparam int QDEPTH      = 2;
	localparam int QPTR_W      = $clog2(QDEPTH);
	localparam int QCNT_W      = $clog2(QDEPTH + 1);
	localparam int S_DATA_W    = 56;
	localparam int M_DATA_W    = 24;

	// Item kinds carried on the request side-band.
	localparam logic MODE_LOAD = 1'b0;
	localparam logic MODE_DRAW = 1'b1;

	// A classified request as held in the queue between front and back.
	typedef struct packed {
		logic                is_draw;
		logic [GIDX_W-1:0]   store_index;
		logic [BYTE_W-1:0]   store_byte;
		logic [GIDX_W-1:0]   glyph_base;
		logic [ADDR_W-1:0]   addr_base;
		logic [SHIFT_W-1:0]  shift;
		logic [COLOUR_W-1:0] colour;
	} cmd_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_FETCH,
		BK_SETTLE,
		BK_EMIT
	} back_state_t;

	// Colour bit that drives a plane; planes past the colour width clear.
	function automatic logic colour_bit(input logic [COLOUR_W-1:0] colour,
		input logic [PLANE_W-1:0] plane);
		logic b;
		b = 1'b0;
		for (int i = 0; i < PLANES; i++) begin
			if (PLANE_W'(i) == plane && i < COLOUR_W) begin
				b = colour[2'(i)];
			end
		end
		return b;
	endfunction

endpackage

### rtl/pgb_front.sv
// Front end of the blitter: unpacks requests, drops draws outside the view
// and precomputes glyph and framebuffer base addresses. Uses pgb_pkg.
module pgb_front (
	input  logic                               s_tvalid,
	input  logic                               s_tuser,
	input  logic [pgb_pkg::S_DATA_W-1:0]       s_tdata,
	input  logic                               q_full,
	output logic                               s_tready,
	output logic                               push,
	output pgb_pkg::cmd_t                      cmd
);

	logic [pgb_pkg::CODE_W-1:0]    code;
	logic [pgb_pkg::POS_W-1:0]     pos_x;
	logic [pgb_pkg::POS_W-1:0]     pos_y;
	logic [pgb_pkg::POS_CMP_W-1:0] x_end;
	logic [pgb_pkg::POS_CMP_W-1:0] y_end;
	logic                          visible;
	logic [pgb_pkg::ADDR_W-1:0]    line_base;

	assign code  = s_tdata[26:19];
	assign pos_x = s_tdata[36:27];
	assign pos_y = s_tdata[46:37];

	assign x_end = pgb_pkg::POS_CMP_W'(pos_x) + pgb_pkg::POS_CMP_W'(pgb_pkg::GLYPH_SIZE);
	assign y_end = pgb_pkg::POS_CMP_W'(pos_y) + pgb_pkg::POS_CMP_W'(pgb_pkg::GLYPH_SIZE);
	assign visible = (x_end <= pgb_pkg::POS_CMP_W'(pgb_pkg::VIEW_WIDTH)) &&
		(y_end <= pgb_pkg::POS_CMP_W'(pgb_pkg::VIEW_HEIGHT));

	assign line_base = pgb_pkg::ADDR_W'(pos_y) * pgb_pkg::ADDR_W'(pgb_pkg::LINE_BYTES);

	always_comb begin
		cmd.is_draw     = (s_tuser == pgb_pkg::MODE_DRAW);
		cmd.store_index = s_tdata[10:0];
		cmd.store_byte  = s_tdata[18:11];
		cmd.glyph_base  = pgb_pkg::GIDX_W'(
			(code / pgb_pkg::GLYPHS_PER_ROW) * pgb_pkg::GLYPH_SIZE * pgb_pkg::GLYPHS_PER_ROW
			+ (code % pgb_pkg::GLYPHS_PER_ROW));
		cmd.addr_base   = line_base + pgb_pkg::ADDR_W'(pos_x[pgb_pkg::POS_W-1:3]);
		cmd.shift       = pos_x[2:0];
		cmd.colour      = s_tdata[50:47];
	end

	assign s_tready = !q_full;
	// Draws that fall outside the view are taken and then forgotten.
	assign push = s_tvalid && s_tready && (!cmd.is_draw || visible);

endmodule

### rtl/pgb_queue.sv
// Short request queue between the front end and the back end.
// Uses the request type from pgb_pkg.
module pgb_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  pgb_pkg::cmd_t push_cmd,
	input  logic          pop,
	output logic          full,
	output logic          empty,
	output pgb_pkg::cmd_t head
);

	pgb_pkg::cmd_t                entry_q [pgb_pkg::QDEPTH];
	logic [pgb_pkg::QPTR_W-1:0]   wr_ptr_q;
	logic [pgb_pkg::QPTR_W-1:0]   rd_ptr_q;
	logic [pgb_pkg::QCNT_W-1:0]   count_q;

	assign full  = (count_q == pgb_pkg::QCNT_W'(pgb_pkg::QDEPTH));
	assign empty = (count_q == '0);
	assign head  = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

### rtl/pgb_back.sv
// Back end of the blitter: owns the glyph store, fetches the eight glyph rows
// of a draw and walks rows, planes and bytes to emit masked writes. Uses pgb_pkg.
module pgb_back (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           q_empty,
	input  pgb_pkg::cmd_t                  head,
	output logic                           pop,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [pgb_pkg::M_DATA_W-1:0]   m_tdata,
	output logic                           m_tlast
);

	pgb_pkg::back_state_t state_q, state_d;

	logic [pgb_pkg::BYTE_W-1:0]   glyph_mem [pgb_pkg::STORE_DEPTH];
	logic [pgb_pkg::BYTE_W-1:0]   rd_data_s1;
	logic                         rd_valid_s1;
	logic [pgb_pkg::ROW_W-1:0]    rd_row_s1;
	logic [pgb_pkg::GIDX_W-1:0]   rd_addr;

	logic [pgb_pkg::GIDX_W-1:0]   glyph_base_q;
	logic [pgb_pkg::SHIFT_W-1:0]  shift_q;
	logic [pgb_pkg::COLOUR_W-1:0] colour_q;
	logic [pgb_pkg::ADDR_W-1:0]   row_base_q;
	logic [pgb_pkg::ADDR_W-1:0]   plane_base_q;
	logic [pgb_pkg::BYTE_W-1:0]   rows_q [pgb_pkg::GLYPH_SIZE];

	logic [pgb_pkg::ROW_W-1:0]    fcnt_q;
	logic [pgb_pkg::ROW_W-1:0]    last_row_q;
	logic [pgb_pkg::ROW_W-1:0]    row_q;
	logic [pgb_pkg::PLANE_W-1:0]  plane_q;
	logic                         half_q;

	logic                         out_valid_q;
	logic [pgb_pkg::ADDR_W-1:0]   out_addr_q;
	logic [pgb_pkg::BYTE_W-1:0]   out_mask_q;
	logic                         out_set_q;
	logic                         out_last_q;

	logic                         take_draw;
	logic                         mem_we;
	logic                         rd_issue;
	logic                         emit_step;
	logic                         out_free;
	logic [2*pgb_pkg::BYTE_W-1:0] pair;
	logic [pgb_pkg::BYTE_W-1:0]   left_mask;
	logic [pgb_pkg::BYTE_W-1:0]   right_mask;
	logic [pgb_pkg::BYTE_W-1:0]   mask;
	logic                         plane_end;
	logic                         row_end;
	logic                         is_last;
	logic                         emit_done;

	assign out_free   = !out_valid_q || m_tready;
	assign pair       = {rows_q[row_q], pgb_pkg::BYTE_W'(0)} >> shift_q;
	assign left_mask  = pair[2*pgb_pkg::BYTE_W-1:pgb_pkg::BYTE_W];
	assign right_mask = pair[pgb_pkg::BYTE_W-1:0];
	assign mask       = half_q ? right_mask : left_mask;
	assign plane_end  = (plane_q == pgb_pkg::PLANE_W'(pgb_pkg::PLANES - 1));
	assign row_end    = (row_q == pgb_pkg::ROW_W'(pgb_pkg::GLYPH_SIZE - 1));
	assign is_last    = (row_q == last_row_q) && plane_end && (half_q || right_mask == '0);
	assign emit_done  = row_end && plane_end && half_q;
	assign rd_addr    = glyph_base_q +
		pgb_pkg::GIDX_W'(fcnt_q) * pgb_pkg::GIDX_W'(pgb_pkg::GLYPHS_PER_ROW);

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			pgb_pkg::BK_IDLE: begin
				if (!q_empty && head.is_draw) begin
					state_d = pgb_pkg::BK_FETCH;
				end
			end
			pgb_pkg::BK_FETCH: begin
				if (fcnt_q == pgb_pkg::ROW_W'(pgb_pkg::GLYPH_SIZE - 1)) begin
					state_d = pgb_pkg::BK_SETTLE;
				end
			end
			pgb_pkg::BK_SETTLE: begin
				state_d = pgb_pkg::BK_EMIT;
			end
			pgb_pkg::BK_EMIT: begin
				if (emit_step && emit_done) begin
					state_d = pgb_pkg::BK_IDLE;
				end
			end
			default: begin
				state_d = pgb_pkg::BK_IDLE;
			end
		endcase
	end

	// State outputs.
	always_comb begin
		pop       = 1'b0;
		take_draw = 1'b0;
		mem_we    = 1'b0;
		rd_issue  = 1'b0;
		emit_step = 1'b0;
		unique case (state_q)
			pgb_pkg::BK_IDLE: begin
				pop       = !q_empty;
				take_draw = !q_empty && head.is_draw;
				mem_we    = !q_empty && !head.is_draw;
			end
			pgb_pkg::BK_FETCH: begin
				rd_issue = 1'b1;
			end
			pgb_pkg::BK_SETTLE: begin
			end
			pgb_pkg::BK_EMIT: begin
				emit_step = (mask == '0) || out_free;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= pgb_pkg::BK_IDLE;
			fcnt_q      <= '0;
			rd_valid_s1 <= 1'b0;
			last_row_q  <= '0;
			row_q       <= '0;
			plane_q     <= '0;
			half_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			rd_valid_s1 <= rd_issue;
			if (take_draw) begin
				fcnt_q     <= '0;
				last_row_q <= '0;
				row_q      <= '0;
				plane_q    <= '0;
				half_q     <= 1'b0;
			end
			if (rd_issue) begin
				fcnt_q <= fcnt_q + 1'b1;
			end
			if (rd_valid_s1 && rd_data_s1 != '0) begin
				last_row_q <= rd_row_s1;
			end
			if (emit_step) begin
				half_q <= !half_q;
				if (half_q) begin
					plane_q <= plane_end ? '0 : plane_q + 1'b1;
					if (plane_end) begin
						row_q <= row_q + 1'b1;
					end
				end
			end
			if (emit_step && mask != '0) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			glyph_mem[head.store_index] <= head.store_byte;
		end
		rd_data_s1 <= glyph_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		rd_row_s1 <= fcnt_q;
		if (take_draw) begin
			glyph_base_q <= head.glyph_base;
			shift_q      <= head.shift;
			colour_q     <= head.colour;
			row_base_q   <= head.addr_base;
			plane_base_q <= head.addr_base;
		end
		if (rd_valid_s1) begin
			rows_q[rd_row_s1] <= rd_data_s1;
		end
		if (emit_step && half_q) begin
			if (plane_end) begin
				row_base_q   <= row_base_q + pgb_pkg::ADDR_W'(pgb_pkg::LINE_BYTES);
				plane_base_q <= row_base_q + pgb_pkg::ADDR_W'(pgb_pkg::LINE_BYTES);
			end else begin
				plane_base_q <= plane_base_q + pgb_pkg::ADDR_W'(pgb_pkg::ROW_BYTES);
			end
		end
		if (emit_step && mask != '0) begin
			out_addr_q <= plane_base_q + pgb_pkg::ADDR_W'(half_q);
			out_mask_q <= mask;
			out_set_q  <= pgb_pkg::colour_bit(colour_q, plane_q);
			out_last_q <= is_last;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_set_q, out_mask_q, out_addr_q};
	assign m_tlast  = out_last_q;

endmodule

### rtl/planar_glyph_blitter.sv
// Planar glyph blitter top level. An accepted load request is held in the queue and written
// into the glyph store when the idle back end pops it. A draw holds the back end through the
// pop, the fetch of its eight glyph rows, a settle state and the row, plane and byte walk,
// one write slot per cycle unless the receiver holds back a pending write.
// Up to two requests wait in the queue while a draw is under way.
// Reset (arst_n low, asynchronous) empties the queue and the output register; the glyph store is not cleared.
module planar_glyph_blitter (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// s_tdata, low bit up: store_index[10:0], store_byte[18:11], char_code[26:19],
	// pos_x[36:27], pos_y[46:37], colour[50:47], zero fill[55:51].
	input  logic [pgb_pkg::S_DATA_W-1:0]   s_tdata,
	// s_tuser: mode (0 = load a glyph byte, 1 = draw a character).
	input  logic                           s_tuser,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// m_tdata, low bit up: write_address[14:0], bit_mask[22:15], set_bits[23].
	output logic [pgb_pkg::M_DATA_W-1:0]   m_tdata,
	// m_tlast: high on the final write of a draw.
	output logic                           m_tlast
);

	// The front end classifies each request and works out its base addresses.
	// Draws whose cell leaves the view are accepted and then dropped here.
	logic          push;
	logic          q_full;
	logic          q_empty;
	logic          pop;
	pgb_pkg::cmd_t push_cmd;
	pgb_pkg::cmd_t head;

	pgb_front u_front (
		.s_tvalid (s_tvalid),
		.s_tuser  (s_tuser),
		.s_tdata  (s_tdata),
		.q_full   (q_full),
		.s_tready (s_tready),
		.push     (push),
		.cmd      (push_cmd)
	);

	// The queue keeps loads and draws in order, so that a draw always sees
	// every glyph byte loaded before it.
	pgb_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.full     (q_full),
		.empty    (q_empty),
		.head     (head)
	);

	// The back end writes loads into the store and walks each draw, holding
	// the finished write in its output register while the next is prepared.
	pgb_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_empty  (q_empty),
		.head     (head),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

endmodule

### dv/tb_top.sv
// Self-checking testbench for the planar glyph blitter: glyph loads and draws are sent
// through the request stream, and every framebuffer write is checked against a model.
// Depends on rtl/pgb_pkg.sv and rtl/planar_glyph_blitter.sv.
module tb_top;
	import pgb_pkg::*;

	localparam int CYCLE_LIMIT  = 2000000;
	localparam int PHASE_ITEMS  = 72;
	localparam int DRAIN_CYCLES = 120;
	localparam int HOLD_STRETCH = 800;

	typedef struct {
		logic [ADDR_W-1:0] addr;
		logic [BYTE_W-1:0] mask;
		logic              set;
		logic              last;
	} blit_write_t;

	// Mirrors the glyph store and turns each accepted request into the framebuffer
	// writes it should cause, then compares the writes as they leave the block.
	class blit_scoreboard;
		logic [BYTE_W-1:0] glyph_rows [STORE_DEPTH];
		blit_write_t       pending_writes [$];
		int                errors;

		function new();
			errors = 0;
			foreach (glyph_rows[i]) glyph_rows[i] = '0;
		endfunction

		task report(string msg);
			errors++;
			$display("%0t mismatch: %s", $time, msg);
		endtask

		function void add_request(logic mode, logic [S_DATA_W-1:0] data);
			int          code, x, y, shift, byte0, bits, left, right, line, base, n;
			logic [COLOUR_W-1:0] colour;
			blit_write_t w;
			if (mode == MODE_LOAD) begin
				glyph_rows[data[10:0]] = data[18:11];
				return;
			end
			code   = data[26:19];
			x      = data[36:27];
			y      = data[46:37];
			colour = data[50:47];
			// A cell that does not fit the viewport draws nothing at all.
			if (x + GLYPH_SIZE > VIEW_WIDTH || y + GLYPH_SIZE > VIEW_HEIGHT) return;
			shift = x % 8;
			byte0 = x / 8;
			n = 0;
			for (int row = 0; row < GLYPH_SIZE; row++) begin
				bits  = glyph_rows[(((code / GLYPHS_PER_ROW) * GLYPH_SIZE + row) * GLYPHS_PER_ROW
					+ code % GLYPHS_PER_ROW) % STORE_DEPTH];
				left  = bits >> shift;
				right = (bits << (8 - shift)) & 8'hFF;
				line  = (y + row) * PLANES * ROW_BYTES;
				for (int plane = 0; plane < PLANES; plane++) begin
					base   = line + plane * ROW_BYTES + byte0;
					w.set  = (plane < COLOUR_W) ? colour[plane] : 1'b0;
					w.last = 1'b0;
					if (left != 0) begin
						w.addr = ADDR_W'(base);
						w.mask = BYTE_W'(left);
						pending_writes.push_back(w);
						n++;
					end
					if (right != 0) begin
						w.addr = ADDR_W'(base + 1);
						w.mask = BYTE_W'(right);
						pending_writes.push_back(w);
						n++;
					end
				end
			end
			if (n > 0) begin
				w = pending_writes.pop_back();
				w.last = 1'b1;
				pending_writes.push_back(w);
			end
		endfunction

		task check_write(logic [M_DATA_W-1:0] data, logic last);
			blit_write_t w;
			if (pending_writes.size() == 0) begin
				report($sformatf("unexpected write addr %0d mask %02h", data[14:0], data[22:15]));
				return;
			end
			w = pending_writes.pop_front();
			if (data[14:0] !== w.addr)
				report($sformatf("write_address %0d, expected %0d", data[14:0], w.addr));
			if (data[22:15] !== w.mask)
				report($sformatf("bit_mask %02h, expected %02h at %0d", data[22:15], w.mask,
					w.addr));
			if (data[23] !== w.set)
				report($sformatf("set_bits %0b, expected %0b at %0d", data[23], w.set, w.addr));
			if (last !== w.last)
				report($sformatf("tlast %0b, expected %0b at %0d", last, w.last, w.addr));
		endtask
	endclass

	logic                clk;
	logic                arst_n;
	logic                s_tvalid;
	logic                s_tready;
	logic [S_DATA_W-1:0] s_tdata;
	logic                s_tuser;
	logic                m_tvalid;
	logic                m_tready;
	logic [M_DATA_W-1:0] m_tdata;
	logic                m_tlast;

	blit_scoreboard sb = new();

	int send_idle;
	int recv_stall;
	int hold_cycles;
	int cycle_count;
	int ready_codes [$];

	planar_glyph_blitter i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// Receiver: random stalls, plus one long hold-off counted down here.
	initial begin
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_cycles > 0) begin
				m_tready <= 1'b0;
				hold_cycles--;
			end else begin
				m_tready <= ($urandom_range(99) >= recv_stall);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) sb.check_write(m_tdata, m_tlast);
	end

	function automatic logic [S_DATA_W-1:0] pack_request(int index, int row_bits, int code,
		int x, int y, int colour);
		logic [S_DATA_W-1:0] d;
		d        = '0;
		d[10:0]  = 11'(index);
		d[18:11] = 8'(row_bits);
		d[26:19] = 8'(code);
		d[36:27] = 10'(x);
		d[46:37] = 10'(y);
		d[50:47] = 4'(colour);
		return d;
	endfunction

	// Offers one request, idling first at the phase's rate, and holds it until taken.
	task automatic send_request(logic mode, logic [S_DATA_W-1:0] data);
		@(negedge clk);
		while ($urandom_range(99) < send_idle) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= mode;
		s_tdata  <= data;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		sb.add_request(mode, data);
	endtask

	// Loads all eight rows of one glyph; row r sits in rows[8r+7:8r].
	task automatic load_glyph(int code, logic [63:0] rows);
		int base;
		base = (code / GLYPHS_PER_ROW) * GLYPH_SIZE * GLYPHS_PER_ROW + code % GLYPHS_PER_ROW;
		for (int r = 0; r < GLYPH_SIZE; r++)
			send_request(MODE_LOAD, pack_request(base + r * GLYPHS_PER_ROW, rows[8*r +: 8],
				$urandom_range(255), $urandom_range(1023), $urandom_range(1023),
				$urandom_range(15)));
		ready_codes.push_back(code);
	endtask

	task automatic draw_glyph(int code, int x, int y, int colour);
		send_request(MODE_DRAW, pack_request($urandom_range(2047), $urandom_range(255), code,
			x, y, colour));
	endtask

	// One random step: a whole glyph load, a stray store write, or a draw.
	// Draws only use fully loaded glyphs, so no unwritten store entry is read.
	task automatic random_step(inout int count);
		int r, code, x, y;
		logic [63:0] rows;
		r = $urandom_range(99);
		if (r < 12) begin
			code = $urandom_range(255);
			for (int i = 0; i < GLYPH_SIZE; i++) begin
				r = $urandom_range(99);
				rows[8*i +: 8] = (r < 20) ? 8'h00 : (r < 30) ? 8'hFF : 8'($urandom_range(255));
			end
			load_glyph(code, rows);
			count += GLYPH_SIZE;
		end else if (r < 25) begin
			send_request(MODE_LOAD, pack_request($urandom_range(2047), $urandom_range(255),
				$urandom_range(255), $urandom_range(1023), $urandom_range(1023),
				$urandom_range(15)));
			count++;
		end else begin
			code = ready_codes[$urandom_range(ready_codes.size() - 1)];
			r = $urandom_range(99);
			if (r < 80) begin
				x = $urandom_range(VIEW_WIDTH - GLYPH_SIZE);
				y = $urandom_range(VIEW_HEIGHT - GLYPH_SIZE);
			end else if (r < 90) begin
				x = VIEW_WIDTH - GLYPH_SIZE - 1 + $urandom_range(2);
				y = VIEW_HEIGHT - GLYPH_SIZE - 1 + $urandom_range(2);
			end else begin
				x = $urandom_range(1023);
				y = $urandom_range(1023);
			end
			draw_glyph(code, x, y, $urandom_range(15));
			count++;
		end
	endtask

	initial begin
		int count;
		arst_n      = 1'b0;
		s_tvalid    = 1'b0;
		s_tuser     = MODE_LOAD;
		s_tdata     = '0;
		send_idle   = 0;
		recv_stall  = 0;
		hold_cycles = 0;
		cycle_count = 0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed part: a busy glyph and a blank one, then two opposite viewport corners,
		// the widest shift and a middle one, both off-viewport edges, a far-off cell and the blank-glyph draw.
		load_glyph(255, 64'h81FF_55AA_0001_80FF);
		load_glyph(0, 64'h0);
		draw_glyph(255, 0, 0, 15);
		draw_glyph(255, VIEW_WIDTH - GLYPH_SIZE, VIEW_HEIGHT - GLYPH_SIZE, 0);
		draw_glyph(255, 7, 10, 5);
		draw_glyph(255, 3, 100, 10);
		draw_glyph(255, VIEW_WIDTH - GLYPH_SIZE + 1, 0, 15);
		draw_glyph(255, 0, VIEW_HEIGHT - GLYPH_SIZE + 1, 15);
		draw_glyph(255, 1023, 1023, 15);
		draw_glyph(0, 40, 40, 15);

		// Random part in four idling phases; the third opens with a long hold-off
		// on the write side so that the request side backs up.
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin send_idle = 0;  recv_stall = 0;  end
				1: begin send_idle = 57; recv_stall = 0;  end
				2: begin send_idle = 0;  recv_stall = 57; hold_cycles = HOLD_STRETCH; end
				default: begin send_idle = 30; recv_stall = 30; end
			endcase
			count = 0;
			while (count < PHASE_ITEMS) random_step(count);
		end

		@(negedge clk);
		s_tvalid <= 1'b0;
		while (sb.pending_writes.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end
endmodule

### filelist.f
rtl/pgb_pkg.sv
rtl/pgb_front.sv
rtl/pgb_queue.sv
rtl/pgb_back.sv
rtl/planar_glyph_blitter.sv
dv/tb_top.sv
